/* hw/rtl/rsl_pkg.sv */
// Shared types and constants for the run-slice line rasterizer.
package rsl_pkg;

   localparam int COORD_BITS = 6;
   localparam int FIELD_BITS = 6;
   localparam int COLOR_BITS = 16;
   localparam int SPAN_BITS  = 6;
   localparam int RUN_BITS   = 7;
   localparam int FRAC_BITS  = 7;
   localparam int ACC_BITS   = 8;
   localparam int COUNT_BITS = 7;
   localparam int PROD_BITS  = 13;
   localparam int STEP_BITS  = 3;

   localparam logic [ACC_BITS-1:0]  ACC_LIMIT  = 8'd100;
   localparam logic [PROD_BITS-1:0] PERCENT    = 13'd100;
   localparam logic [STEP_BITS-1:0] QUO_FIRST  = 3'(SPAN_BITS - 1);
   localparam logic [STEP_BITS-1:0] FRAC_FIRST = 3'(FRAC_BITS - 1);

   typedef struct packed {
      logic down;
      logic y_minor;
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [COUNT_BITS-1:0]   count;
      logic [SPAN_BITS-1:0]    quotient;
      logic [FRAC_BITS-1:0]    fraction;
      logic [FIELD_BITS-1:0]   thickness;
      logic [COLOR_BITS-1:0]   color;
   } job_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   typedef enum logic [4:0] {
      F_IDLE  = 5'b00001,
      F_QUO   = 5'b00010,
      F_SCALE = 5'b00100,
      F_FRAC  = 5'b01000,
      F_PUSH  = 5'b10000
   } front_state_type;

endpackage

/* hw/rtl/rsl_req_if.sv */
// Request channel of the line rasterizer: endpoints, thickness and color.
interface rsl_req_if import rsl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] x_start;
   logic [FIELD_BITS-1:0] y_start;
   logic [FIELD_BITS-1:0] x_end;
   logic [FIELD_BITS-1:0] y_end;
   logic [FIELD_BITS-1:0] thickness;
   logic [COLOR_BITS-1:0] color;

   modport source (output valid, x_start, y_start, x_end, y_end, thickness, color,
                   input ready);
   modport sink (input valid, x_start, y_start, x_end, y_end, thickness, color,
                 output ready);
endinterface

/* hw/rtl/rsl_rsp_if.sv */
// Result channel of the line rasterizer: one rectangle per transfer.
interface rsl_rsp_if import rsl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] rect_x;
   logic [FIELD_BITS-1:0] rect_y;
   logic [FIELD_BITS-1:0] rect_w;
   logic [FIELD_BITS-1:0] rect_h;
   logic [COLOR_BITS-1:0] rect_color;
   logic                  last_rect;

   modport source (output valid, rect_x, rect_y, rect_w, rect_h, rect_color, last_rect,
                   input ready);
   modport sink (input valid, rect_x, rect_y, rect_w, rect_h, rect_color, last_rect,
                 output ready);
endinterface

/* hw/rtl/rsl_front.sv */
// Front end: accepts a line request, orders the endpoints and runs the serial divider.
module rsl_front import rsl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rsl_req_if.sink               req,
   output job_ctl_type           job_ctl,
   output logic [COORD_BITS-1:0] job_major_start,
   output logic [COORD_BITS-1:0] job_minor_low,
   output logic                  push_valid,
   input  logic                  push_ready
);

   localparam int WIDE_BITS = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

   front_state_type         state_ff, state_in;
   job_ctl_type             ctl_ff, ctl_in;
   logic [COORD_BITS-1:0]   maj_ff, maj_in;
   logic [COORD_BITS-1:0]   lo_ff, lo_in;
   logic [SPAN_BITS-1:0]    minor_ff, minor_in;
   logic [SPAN_BITS-1:0]    rem_ff, rem_in;
   logic [PROD_BITS-1:0]    dvd_ff, dvd_in;
   logic [FRAC_BITS-1:0]    qsh_ff, qsh_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;

   logic [WIDE_BITS-1:0]    xs_w, ys_w, xe_w, ye_w, dx_w, dy_w, cnt_w;
   logic [COORD_BITS-1:0]   xs, ys, xe, ye, dx, dy, m_lo, m_hi, maj_start, maj_end;
   logic [SPAN_BITS-1:0]    xlen, ylen, major, minor;
   logic                    y_minor, x_swap, y_swap;
   logic [COUNT_BITS-1:0]   count;

   logic [SPAN_BITS:0]      trial, trial_sub;
   logic                    ge;
   logic [SPAN_BITS-1:0]    rem_step;
   logic [FRAC_BITS-1:0]    qsh_step;
   logic [PROD_BITS-1:0]    prod;

   assign xs_w = WIDE_BITS'(req.x_start);
   assign ys_w = WIDE_BITS'(req.y_start);
   assign xe_w = WIDE_BITS'(req.x_end);
   assign ye_w = WIDE_BITS'(req.y_end);
   assign xs   = xs_w[COORD_BITS-1:0];
   assign ys   = ys_w[COORD_BITS-1:0];
   assign xe   = xe_w[COORD_BITS-1:0];
   assign ye   = ye_w[COORD_BITS-1:0];

   assign x_swap = xs > xe;
   assign y_swap = ys > ye;
   assign dx     = x_swap ? xs - xe : xe - xs;
   assign dy     = y_swap ? ys - ye : ye - ys;
   assign dx_w   = WIDE_BITS'(dx);
   assign dy_w   = WIDE_BITS'(dy);
   assign xlen   = (dx_w[SPAN_BITS-1:0] == '0) ? SPAN_BITS'(1) : dx_w[SPAN_BITS-1:0];
   assign ylen   = (dy_w[SPAN_BITS-1:0] == '0) ? SPAN_BITS'(1) : dy_w[SPAN_BITS-1:0];
   assign y_minor = !(xlen <= ylen);

   always_comb begin
      if (!y_minor) begin
         m_lo      = x_swap ? xe : xs;
         m_hi      = x_swap ? xs : xe;
         maj_start = x_swap ? ye : ys;
         maj_end   = x_swap ? ys : ye;
         major     = ylen;
         minor     = xlen;
      end else begin
         m_lo      = y_swap ? ye : ys;
         m_hi      = y_swap ? ys : ye;
         maj_start = y_swap ? xe : xs;
         maj_end   = y_swap ? xs : xe;
         major     = xlen;
         minor     = ylen;
      end
   end

   assign cnt_w = WIDE_BITS'(m_hi - m_lo);
   assign count = {1'b0, cnt_w[SPAN_BITS-1:0]} + COUNT_BITS'(1);

   // One restoring division step shared by the quotient and fraction phases.
   assign trial     = {rem_ff, dvd_ff[PROD_BITS-1]};
   assign trial_sub = trial - {1'b0, minor_ff};
   assign ge        = trial >= {1'b0, minor_ff};
   assign rem_step  = ge ? trial_sub[SPAN_BITS-1:0] : trial[SPAN_BITS-1:0];
   assign qsh_step  = {qsh_ff[FRAC_BITS-2:0], ge};
   assign prod      = PROD_BITS'(rem_ff) * PERCENT;

   always_comb begin
      state_in = state_ff;
      ctl_in   = ctl_ff;
      maj_in   = maj_ff;
      lo_in    = lo_ff;
      minor_in = minor_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      qsh_in   = qsh_ff;
      step_in  = step_ff;
      case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               ctl_in.mode.y_minor = y_minor;
               ctl_in.mode.down    = maj_end < maj_start;
               ctl_in.count        = count;
               ctl_in.thickness    = req.thickness;
               ctl_in.color        = req.color;
               maj_in   = maj_start;
               lo_in    = m_lo;
               minor_in = minor;
               rem_in   = '0;
               dvd_in   = {major, FRAC_BITS'(0)};
               qsh_in   = '0;
               step_in  = QUO_FIRST;
               state_in = F_QUO;
            end
         end
         F_QUO: begin
            rem_in  = rem_step;
            dvd_in  = {dvd_ff[PROD_BITS-2:0], 1'b0};
            qsh_in  = qsh_step;
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = F_SCALE;
            end
         end
         F_SCALE: begin
            ctl_in.quotient = qsh_ff[SPAN_BITS-1:0];
            rem_in   = prod[PROD_BITS-1:FRAC_BITS];
            dvd_in   = {prod[FRAC_BITS-1:0], SPAN_BITS'(0)};
            qsh_in   = '0;
            step_in  = FRAC_FIRST;
            state_in = F_FRAC;
         end
         F_FRAC: begin
            rem_in          = rem_step;
            dvd_in          = {dvd_ff[PROD_BITS-2:0], 1'b0};
            qsh_in          = qsh_step;
            ctl_in.fraction = qsh_step;
            step_in         = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff   <= ctl_in;
      maj_ff   <= maj_in;
      lo_ff    <= lo_in;
      minor_ff <= minor_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      qsh_ff   <= qsh_in;
      step_ff  <= step_in;
   end

   assign req.ready       = state_ff == F_IDLE;
   assign push_valid      = state_ff == F_PUSH;
   assign job_ctl         = ctl_ff;
   assign job_major_start = maj_ff;
   assign job_minor_low   = lo_ff;

endmodule

/* hw/rtl/rsl_queue.sv */
// Small FIFO that holds prepared line jobs between the front and back ends.
module rsl_queue import rsl_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready,
   output queue_status_type status
);

   localparam int PTR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = fill_ff != (PTR_BITS + 1)'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PTR_BITS + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign status.full  = !push_ready;
   assign status.empty = !pop_valid;

endmodule

/* hw/rtl/rsl_back.sv */
// Back end: steps along the minor axis and emits one rectangle per step.
module rsl_back import rsl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  job_ctl_type           job_ctl,
   input  logic [COORD_BITS-1:0] job_major_start,
   input  logic [COORD_BITS-1:0] job_minor_low,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   rsl_rsp_if.source             rsp,
   output back_status_type       status
);

   localparam int WORK_BITS = (COORD_BITS > RUN_BITS) ? COORD_BITS : RUN_BITS;
   localparam int OUT_BITS  = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

   logic                  busy_ff, busy_in;
   logic                  out_valid_ff, out_valid_in;
   job_ctl_type           job_ff, job_in;
   logic [COORD_BITS-1:0] pos_ff, pos_in;
   logic [COORD_BITS-1:0] idx_ff, idx_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [COUNT_BITS-1:0] k_ff, k_in;
   logic [FIELD_BITS-1:0] rect_x_ff, rect_x_in, rect_y_ff, rect_y_in;
   logic [FIELD_BITS-1:0] rect_w_ff, rect_w_in, rect_h_ff, rect_h_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  last_ff, last_in;

   logic                  do_pop, advance, extra, is_last;
   logic [RUN_BITS-1:0]   run;
   logic [ACC_BITS-1:0]   acc_sub;
   logic [WORK_BITS-1:0]  pos_w, run_w, pos_next_w;
   logic [OUT_BITS-1:0]   pos_o, idx_o;
   logic [COUNT_BITS-1:0] k_next;

   assign pop_ready = !busy_ff;
   assign do_pop    = pop_valid && !busy_ff;
   assign advance   = busy_ff && (!out_valid_ff || rsp.ready);

   assign extra      = acc_ff > ACC_LIMIT;
   assign run        = RUN_BITS'(job_ff.quotient) + (extra ? RUN_BITS'(1) : RUN_BITS'(0));
   assign acc_sub    = extra ? acc_ff - ACC_LIMIT : acc_ff;
   assign pos_w      = WORK_BITS'(pos_ff);
   assign run_w      = WORK_BITS'(run);
   assign pos_next_w = job_ff.mode.down ? pos_w - run_w : pos_w + run_w;
   assign pos_o      = OUT_BITS'(pos_ff);
   assign idx_o      = OUT_BITS'(idx_ff);
   assign k_next     = k_ff + COUNT_BITS'(1);
   assign is_last    = k_next == job_ff.count;

   always_comb begin
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      rect_x_in    = rect_x_ff;
      rect_y_in    = rect_y_ff;
      rect_w_in    = rect_w_ff;
      rect_h_in    = rect_h_ff;
      color_in     = color_ff;
      last_in      = last_ff;
      if (do_pop) begin
         busy_in = 1'b1;
         job_in  = job_ctl;
         pos_in  = job_major_start;
         idx_in  = job_minor_low;
         acc_in  = '0;
         k_in    = '0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         if (!job_ff.mode.y_minor) begin
            rect_x_in = idx_o[FIELD_BITS-1:0];
            rect_y_in = pos_o[FIELD_BITS-1:0];
            rect_w_in = job_ff.thickness;
            rect_h_in = run[FIELD_BITS-1:0];
         end else begin
            rect_x_in = pos_o[FIELD_BITS-1:0];
            rect_y_in = idx_o[FIELD_BITS-1:0];
            rect_w_in = run[FIELD_BITS-1:0];
            rect_h_in = job_ff.thickness;
         end
         color_in = job_ff.color;
         last_in  = is_last;
         pos_in   = pos_next_w[COORD_BITS-1:0];
         acc_in   = acc_sub + ACC_BITS'(job_ff.fraction);
         k_in     = k_next;
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + COORD_BITS'(1);
         end
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      acc_ff    <= acc_in;
      k_ff      <= k_in;
      rect_x_ff <= rect_x_in;
      rect_y_ff <= rect_y_in;
      rect_w_ff <= rect_w_in;
      rect_h_ff <= rect_h_in;
      color_ff  <= color_in;
      last_ff   <= last_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.rect_x     = rect_x_ff;
   assign rsp.rect_y     = rect_y_ff;
   assign rsp.rect_w     = rect_w_ff;
   assign rsp.rect_h     = rect_h_ff;
   assign rsp.rect_color = color_ff;
   assign rsp.last_rect  = last_ff;
   assign status.busy    = busy_ff;

endmodule

/* hw/rtl/run_slice_line_rasterizer.sv */
// Top level of the run-slice line rasterizer: front end, job queue and back end.
//
//   Channel   Direction  Handshake      Contents
//   req_bus   in         valid/ready    x_start, y_start, x_end, y_end, thickness, color
//   rsp_bus   out        valid/ready    rect_x, rect_y, rect_w, rect_h, rect_color, last_rect
//
// The front end takes a new request only once it has handed the last job to the queue. Its
// steps are the accept, six quotient steps and seven fraction steps of its serial divider,
// one scaling step and the handoff to the queue. The back end emits one rectangle per cycle
// while the receiver keeps accepting them.
// Reset is synchronous and clears the state machines, the queue fill and the valid flag.
// A stalled response holds the back end; the two-entry queue lets the front keep working.
module run_slice_line_rasterizer import rsl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rsl_req_if.sink   req_bus,
   rsl_rsp_if.source rsp_bus
);

   localparam int JOB_BITS    = $bits(job_ctl_type) + 2 * COORD_BITS;
   localparam int QUEUE_DEPTH = 2;

   job_ctl_type           front_ctl, back_ctl;
   logic [COORD_BITS-1:0] front_major, front_low, back_major, back_low;
   logic                  push_valid, push_ready, pop_valid, pop_ready;
   logic [JOB_BITS-1:0]   push_data, pop_data;
   queue_status_type      queue_status;
   back_status_type       back_status;

   rsl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req             (req_bus),
      .job_ctl         (front_ctl),
      .job_major_start (front_major),
      .job_minor_low   (front_low),
      .push_valid      (push_valid),
      .push_ready      (push_ready)
   );

   assign push_data = {front_ctl, front_major, front_low};

   rsl_queue #(.WIDTH(JOB_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .status     (queue_status)
   );

   assign {back_ctl, back_major, back_low} = pop_data;

   rsl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_ctl         (back_ctl),
      .job_major_start (back_major),
      .job_minor_low   (back_low),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .rsp             (rsp_bus),
      .status          (back_status)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid && queue_status.full |-> !push_ready)
      else $error("Job pushed into a full queue.");

   a_pop_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |-> !back_status.busy && !queue_status.empty)
      else $error("Job popped while the back end was busy or the queue was empty.");

   a_line_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_rect |-> back_status.busy)
      else $error("Back end went idle before the final rectangle of a line.");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid
         && $stable({rsp_bus.rect_x, rsp_bus.rect_y, rsp_bus.rect_w, rsp_bus.rect_h,
                     rsp_bus.rect_color, rsp_bus.last_rect}))
      else $error("Waiting rectangle changed before it was accepted.");

endmodule

/* tb/rsl_line_checker.sv */
// Watches both channels, predicts the rectangles of each line and compares them as they leave.
module rsl_line_checker import rsl_pkg::*; (
   input  logic clock,
   input  logic reset,
   rsl_req_if   req_bus,
   rsl_rsp_if   rsp_bus,
   output int   fail_count,
   output int   pending_rects
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRACTION_SCALE = 100;
   localparam int unsigned MAX_RECTS      = 64;
   localparam int unsigned COORD_MASK     = (1 << FIELD_BITS) - 1;

   typedef struct packed {
      logic [FIELD_BITS-1:0] x;
      logic [FIELD_BITS-1:0] y;
      logic [FIELD_BITS-1:0] w;
      logic [FIELD_BITS-1:0] h;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } rect_type;

   rect_type rect_expectations[$];
   rect_type want;

   initial begin
      fail_count    = 0;
      pending_rects = 0;
   end

   function automatic int unsigned span_between(input int unsigned a, input int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return (d == 0) ? 1 : d;
   endfunction

   // Splits one line into runs along its major axis and queues the rectangles it must produce.
   function automatic void plan_line_rects(input logic [FIELD_BITS-1:0] xs, ys, xe, ye, thick,
                                           input logic [COLOR_BITS-1:0] color);
      int unsigned x_span, y_span, lo, hi, start, stop, major, minor;
      int unsigned quotient, fraction, accum, pos, idx, count, run;
      mode_type    mode;
      rect_type    r;
      x_span       = span_between(xs, xe);
      y_span       = span_between(ys, ye);
      mode.y_minor = x_span > y_span;
      if (!mode.y_minor) begin
         if (xs > xe) begin
            lo = xe; hi = xs; start = ye; stop = ys;
         end else begin
            lo = xs; hi = xe; start = ys; stop = ye;
         end
         major = y_span;
         minor = x_span;
      end else begin
         if (ys > ye) begin
            lo = ye; hi = ys; start = xe; stop = xs;
         end else begin
            lo = ys; hi = ye; start = xs; stop = xe;
         end
         major = x_span;
         minor = y_span;
      end
      mode.down = stop < start;
      quotient  = major / minor;
      fraction  = (major * FRACTION_SCALE) / minor - quotient * FRACTION_SCALE;
      accum     = 0;
      pos       = start;
      idx       = lo;
      count     = hi - lo + 1;
      if (count > MAX_RECTS) begin
         count = MAX_RECTS;
      end
      for (int unsigned k = 0; k < count; k++) begin
         if (accum > FRACTION_SCALE) begin
            run   = quotient + 1;
            accum = accum - FRACTION_SCALE;
         end else begin
            run = quotient;
         end
         r.color = color;
         r.last  = (k + 1 == count);
         if (!mode.y_minor) begin
            r.x = FIELD_BITS'(idx);
            r.y = FIELD_BITS'(pos);
            r.w = thick;
            r.h = FIELD_BITS'(run);
         end else begin
            r.x = FIELD_BITS'(pos);
            r.y = FIELD_BITS'(idx);
            r.w = FIELD_BITS'(run);
            r.h = thick;
         end
         rect_expectations.push_back(r);
         pos   = mode.down ? ((pos - run) & COORD_MASK) : ((pos + run) & COORD_MASK);
         accum = accum + fraction;
         idx   = (idx + 1) & COORD_MASK;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned expected,
                                       input int unsigned actual);
      if (expected != actual) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            plan_line_rects(req_bus.x_start, req_bus.y_start, req_bus.x_end, req_bus.y_end,
                            req_bus.thickness, req_bus.color);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rect_expectations.size() == 0) begin
               $display("%0t: rectangle x=%0d y=%0d w=%0d h=%0d arrived with no line pending",
                        $time, rsp_bus.rect_x, rsp_bus.rect_y, rsp_bus.rect_w, rsp_bus.rect_h);
               fail_count++;
            end else begin
               want = rect_expectations.pop_front();
               check_field("rect_x", want.x, rsp_bus.rect_x);
               check_field("rect_y", want.y, rsp_bus.rect_y);
               check_field("rect_w", want.w, rsp_bus.rect_w);
               check_field("rect_h", want.h, rsp_bus.rect_h);
               check_field("rect_color", want.color, rsp_bus.rect_color);
               check_field("last_rect", want.last, rsp_bus.last_rect);
            end
         end
      end
      pending_rects <= rect_expectations.size();
   end

endmodule

/* tb/tb_run_slice_line_rasterizer.sv */
// Testbench top: clock, reset, line requests, receiver back-pressure and the final verdict.
module tb_run_slice_line_rasterizer;
   import rsl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_LINES = 90;
   localparam int HOLD_CYCLES  = 250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 40;

   logic clock;
   logic reset;
   bit   steady;
   bit   squeeze;
   bit   squeezed;
   int   fail_count;
   int   pending_rects;
   int   quiet_cycles;

   rsl_req_if req_bus ();
   rsl_rsp_if rsp_bus ();

   run_slice_line_rasterizer DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rsl_line_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_rects (pending_rects)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_line(input logic [FIELD_BITS-1:0] xs, ys, xe, ye, thick,
                            input logic [COLOR_BITS-1:0] color);
      while (!steady && $urandom_range(99) < 8) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.x_start   <= xs;
      req_bus.y_start   <= ys;
      req_bus.x_end     <= xe;
      req_bus.y_end     <= ye;
      req_bus.thickness <= thick;
      req_bus.color     <= color;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // The receiver stalls now and then, and once for a long stretch so the request side backs up.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeezed) begin
            squeezed = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 8);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [FIELD_BITS-1:0] xs, ys, xe, ye, thick;
      int kind;
      req_bus.valid     <= 1'b0;
      req_bus.x_start   <= '0;
      req_bus.y_start   <= '0;
      req_bus.x_end     <= '0;
      req_bus.y_end     <= '0;
      req_bus.thickness <= '0;
      req_bus.color     <= '0;
      reset             <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_line(6'd0, 6'd0, 6'd0, 6'd0, 6'd1, 16'h0000);
      send_line(6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 16'hFFFF);
      send_line(6'd0, 6'd0, 6'd63, 6'd63, 6'd1, 16'h1234);
      send_line(6'd63, 6'd63, 6'd0, 6'd0, 6'd2, 16'hA5A5);
      send_line(6'd0, 6'd63, 6'd63, 6'd0, 6'd3, 16'h5A5A);
      send_line(6'd63, 6'd0, 6'd0, 6'd63, 6'd4, 16'hFF00);
      send_line(6'd0, 6'd5, 6'd63, 6'd5, 6'd5, 16'h00FF);
      send_line(6'd7, 6'd0, 6'd7, 6'd63, 6'd6, 16'h8001);
      send_line(6'd0, 6'd0, 6'd63, 6'd10, 6'd3, 16'h7FFE);
      send_line(6'd63, 6'd0, 6'd0, 6'd10, 6'd2, 16'hC3C3);
      send_line(6'd0, 6'd10, 6'd63, 6'd0, 6'd1, 16'h3C3C);
      send_line(6'd10, 6'd0, 6'd0, 6'd63, 6'd8, 16'h0F0F);
      send_line(6'd20, 6'd20, 6'd21, 6'd20, 6'd0, 16'hF0F0);
      send_line(6'd0, 6'd0, 6'd1, 6'd1, 6'd0, 16'h0001);
      send_line(6'd5, 6'd0, 6'd45, 6'd3, 6'd63, 16'h8000);
      send_line(6'd3, 6'd0, 6'd8, 6'd63, 6'd32, 16'h4000);
      send_line(6'd0, 6'd0, 6'd62, 6'd31, 6'd16, 16'h2222);
      send_line(6'd0, 6'd0, 6'd63, 6'd62, 6'd1, 16'hDEAD);
      send_line(6'd0, 6'd0, 6'd63, 6'd2, 6'd7, 16'hBEEF);
      send_line(6'd40, 6'd50, 6'd40, 6'd50, 6'd63, 16'hFFFE);

      for (int i = 0; i < RANDOM_LINES; i++) begin
         steady  = (i >= 50) && (i < 80);
         squeeze = squeeze || (i == 30);
         kind    = $urandom_range(99);
         xs      = 6'($urandom_range(63));
         ys      = 6'($urandom_range(63));
         if (kind < 55) begin
            xe = 6'($urandom_range(63));
            ye = 6'($urandom_range(63));
         end else if (kind < 85) begin
            xe = 6'(xs + $urandom_range(8) - 4);
            ye = 6'(ys + $urandom_range(8) - 4);
         end else if (kind < 92) begin
            xe = xs;
            ye = 6'($urandom_range(63));
         end else begin
            xe = 6'($urandom_range(63));
            ye = ($urandom_range(1) == 0) ? ys : 6'(ys + (xe - xs));
         end
         thick = ($urandom_range(9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
         send_line(xs, ys, xe, ye, thick, 16'($urandom_range(65535)));
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_rects != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_rects == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
